FILE: design/format_string_int_hex_formatter_assert.svh
// assertion macros for the formatter
`ifndef FORMAT_STRING_INT_HEX_FORMATTER_ASSERT_SVH
`define FORMAT_STRING_INT_HEX_FORMATTER_ASSERT_SVH
`define FSH_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
`define FSH_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: design/fshf_pkg.sv
// types and constants for the formatter
package fshf_pkg;
  typedef struct packed {
    logic [7:0]  format_byte;
    logic signed [31:0] argument_value;
  } in_word_t;
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        end_of_string;
    logic [31:0] chars_written;
  } out_word_t;
  localparam logic [7:0] ChPct = 8'h25;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChD   = 8'h64;
  localparam logic [7:0] ChX   = 8'h78;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChMin = 8'h2d;
  localparam logic [7:0] ChZer = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction
endpackage

FILE: design/fshf_digit_unit.sv
// shared divide-by-base unit, reciprocal multiply for ten and shift for sixteen
module fshf_digit_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  input  logic        hex_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [3:0]  rem_o
);
  localparam logic [31:0] RecipTen = 32'hcccc_cccd;
  logic [31:0] val_q;
  logic        hex_q, done_q;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [3:0]  q10;
  assign prod = {32'd0, val_q} * {32'd0, RecipTen};
  assign quot = hex_q ? {4'd0, val_q[31:4]} : {3'd0, prod[63:35]};
  // low four bits of quotient times ten
  assign q10 = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      hex_q <= hex_i;
    end
  end
  assign done_o = done_q;
  assign quot_o = quot;
  assign rem_o  = hex_q ? val_q[3:0] : (val_q[3:0] - q10);
endmodule

FILE: design/format_string_int_hex_formatter.sv
// format string formatter top level
// latency: plain byte result valid the cycle after the word is accepted
// conversion: each digit passes S_ONE and S_DIV on the shared divide unit, then a
// setup state, then one character per cycle while the output is taken
// throughput: one word at a time; not ready until all results are taken
// reset: asynchronous active low, clears parse state and the character count
module format_string_int_hex_formatter #(
  parameter int MAX_FIELD = 63
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fshf_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fshf_pkg::out_word_t out_data_o
);
  import fshf_pkg::*;
  localparam int FW = $clog2(MAX_FIELD + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_WAIT = 3'd2,
                         S_EMIT = 3'd3, S_ONE = 3'd4;
  logic [2:0] st_q, st_d;
  logic [1:0] mode_q, mode_d;
  logic [FW-1:0] fw_q, fw_d, pr_q, pr_d;
  logic pg_q, pg_d;
  logic [31:0] tot_q, tot_d;
  logic [3:0] digs_q [16];
  logic [4:0] nd_q, nd_d;
  logic neg_q, neg_d, hex_q, hex_d;
  logic [31:0] mag_q, mag_d;
  logic [8:0] spc_q, spc_d, zer_q, zer_d;
  logic ov_q, ov_d;
  out_word_t ow_q, ow_d;
  logic [7:0] one_q, one_d;
  logic one_end_q, one_end_d;
  logic dstart, ddone, wr_dig;
  logic [31:0] dquot;
  logic [3:0] drem;
  logic acc;
  logic [7:0] b;
  logic [11:0] accv;
  logic [FW-1:0] cur;
  logic [8:0] used;
  logic [8:0] pr9, fw9;

  fshf_digit_unit u_div (.clk_i, .rst_ni, .start_i(dstart), .value_i(mag_q),
    .hex_i(hex_q), .done_o(ddone), .quot_o(dquot), .rem_o(drem));

  assign in_ready_o = (st_q == S_IDLE) && !ov_q;
  assign acc = in_valid_i && in_ready_o;
  assign b = in_data_i.format_byte;
  assign cur = (mode_q == 2'd1) ? fw_q : pr_q;
  assign accv = {{(12-FW){1'b0}}, cur} * 12'd10 + {8'd0, b[3:0]};
  assign pr9 = 9'(pr_q);
  assign fw9 = 9'(fw_q);
  assign used = {8'd0, neg_q} + ((pr9 > 9'(nd_q)) ? pr9 : 9'(nd_q));
  assign out_valid_o = ov_q;
  assign out_data_o = ow_q;

  always_comb begin
    st_d = st_q; mode_d = mode_q; fw_d = fw_q; pr_d = pr_q; pg_d = pg_q; tot_d = tot_q;
    nd_d = nd_q; neg_d = neg_q; hex_d = hex_q; mag_d = mag_q; spc_d = spc_q; zer_d = zer_q;
    ov_d = ov_q; ow_d = ow_q; one_d = one_q; one_end_d = one_end_q;
    dstart = 1'b0; wr_dig = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          if (b == 8'd0) begin
            ow_d = '{8'd0, 1'b1, 1'b1, tot_q}; ov_d = 1'b1;
            tot_d = '0; mode_d = '0; fw_d = '0; pr_d = '0; pg_d = 1'b0;
          end else if (mode_q == 2'd0) begin
            if (b == ChPct) begin
              mode_d = 2'd1; fw_d = '0; pr_d = '0; pg_d = 1'b0;
            end else begin
              tot_d = tot_q + 32'd1; ow_d = '{b, 1'b1, 1'b0, tot_q + 32'd1}; ov_d = 1'b1;
            end
          end else if (b inside {[ChZer:ChNine]}) begin
            if (mode_q == 2'd1) fw_d = (accv > 12'(MAX_FIELD)) ? FW'(MAX_FIELD) : accv[FW-1:0];
            else pr_d = (accv > 12'(MAX_FIELD)) ? FW'(MAX_FIELD) : accv[FW-1:0];
          end else if (b == ChDot && mode_q == 2'd1) begin
            mode_d = 2'd2; pg_d = 1'b1;
          end else if (b == ChD || b == ChX) begin
            hex_d = (b == ChX);
            neg_d = (b == ChD) && in_data_i.argument_value[31];
            mag_d = neg_d ? (32'd0 - in_data_i.argument_value) : in_data_i.argument_value;
            nd_d = '0; mode_d = '0;
            if (pg_q && pr_q == '0 && mag_d == '0) st_d = S_WAIT;
            else st_d = S_ONE;
          end else begin
            mode_d = '0; fw_d = '0; pr_d = '0; pg_d = 1'b0;
          end
        end
      end
      S_ONE: begin
        dstart = 1'b1; st_d = S_DIV;
      end
      S_DIV: begin
        if (ddone) begin
          wr_dig = 1'b1; nd_d = nd_q + 5'd1; mag_d = dquot;
          st_d = (dquot != '0 && nd_q != 5'd15) ? S_ONE : S_WAIT;
        end
      end
      S_WAIT: begin
        spc_d = (fw9 > used) ? fw9 - used : 9'd0;
        zer_d = (pr9 > 9'(nd_q)) ? pr9 - 9'(nd_q) : 9'd0;
        st_d = S_EMIT;
      end
      S_EMIT: begin
        if (!ov_q || out_ready_i) begin
          if (spc_q != '0) begin
            one_d = ChSp; spc_d = spc_q - 9'd1;
          end else if (neg_q) begin
            one_d = ChMin; neg_d = 1'b0;
          end else if (zer_q != '0) begin
            one_d = ChZer; zer_d = zer_q - 9'd1;
          end else if (nd_q != '0) begin
            one_d = hex_char(digs_q[nd_q[3:0] - 4'd1]); nd_d = nd_q - 5'd1;
          end
          one_end_d = (spc_d == '0) && !neg_d && (zer_d == '0) && (nd_d == '0);
          if (spc_q != '0 || neg_q || zer_q != '0 || nd_q != '0) begin
            tot_d = tot_q + 32'd1; ow_d = '{one_d, one_end_d, 1'b0, tot_q + 32'd1};
            ov_d = 1'b1;
          end
          if (one_end_d) begin
            st_d = S_IDLE; fw_d = '0; pr_d = '0; pg_d = 1'b0;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; mode_q <= '0; fw_q <= '0; pr_q <= '0; pg_q <= 1'b0;
      tot_q <= '0; ov_q <= 1'b0; nd_q <= '0; neg_q <= 1'b0;
    end else begin
      st_q <= st_d; mode_q <= mode_d; fw_q <= fw_d; pr_q <= pr_d; pg_q <= pg_d;
      tot_q <= tot_d; ov_q <= ov_d; nd_q <= nd_d; neg_q <= neg_d;
    end
  end
  always_ff @(posedge clk_i) begin
    hex_q <= hex_d; mag_q <= mag_d; spc_q <= spc_d; zer_q <= zer_d; ow_q <= ow_d;
    one_q <= one_d; one_end_q <= one_end_d;
    if (wr_dig) digs_q[nd_q[3:0]] <= drem;
  end

`include "format_string_int_hex_formatter_assert.svh"
  `FSH_ASSERT_IMPL(a_no_acc_busy, st_q != S_IDLE, !in_ready_o)
  `FSH_ASSERT_NEXT(a_eos_clears, acc && b == 8'd0, tot_q == '0 && mode_q == '0)
  `FSH_ASSERT_IMPL(a_nd_bound, 1'b1, nd_q <= 5'd16)
endmodule
